// ===== hw/rtl/translation_table_slot_pool_unit_macros.svh =====
// Assertion shorthands shared by the slot pool modules.
`ifndef TRANSLATION_TABLE_SLOT_POOL_UNIT_MACROS_SVH
`define TRANSLATION_TABLE_SLOT_POOL_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TTSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot pool assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TTSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot pool assertion failed");

`endif

// ===== hw/rtl/ttsp_pkg.sv =====
`default_nettype none

package ttsp_pkg;

    localparam int SLOT_COUNT  = 4;
    localparam int MAP_ID_BITS = 16;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
    localparam int CMD_W       = 2;
    localparam int IDX_W       = 3;
    localparam int GRANT_W     = 2;
    localparam int EVMAP_W     = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIGHT   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [MAP_ID_BITS-1:0] map_id;
        logic [IDX_W-1:0]       slot_index;
    } t_in_word;

    typedef struct packed {
        logic [GRANT_W-1:0] granted_slot;
        logic               was_hit;
        logic               needs_fill;
        logic               did_evict;
        logic [EVMAP_W-1:0] evicted_map;
        logic               fault;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic take;
        logic scan_step;
        logic start_evict;
        logic evict_step;
        logic commit;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic do_scan;
        logic scan_last;
        logic need_evict;
        logic ev_free;
        logic ev_last;
        logic out_busy;
    } t_ctrl_stat;

    // round-robin successor, wraps at the pool size
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(SLOT_COUNT - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ttsp_dp.sv =====
`default_nettype none

`include "translation_table_slot_pool_unit_macros.svh"

module ttsp_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ttsp_pkg::t_in_word   i_in_word,
    input  ttsp_pkg::t_ctrl_cmd  i_cmd,
    output ttsp_pkg::t_ctrl_stat o_stat,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output ttsp_pkg::t_out_word  o_out_word
);

    localparam int N  = ttsp_pkg::SLOT_COUNT;
    localparam int SW = ttsp_pkg::SLOT_W;
    localparam int CW = ttsp_pkg::CNT_W;
    localparam int MW = ttsp_pkg::MAP_ID_BITS;

    // slot state
    logic [N-1:0]  r_busy,   n_busy;
    logic [MW-1:0] r_map [N];
    logic [MW-1:0] n_map [N];
    logic [CW-1:0] r_filled, n_filled;
    logic [SW-1:0] r_ptr,    n_ptr;
    logic [MW-1:0] r_last,   n_last;

    // request context and scan bookkeeping
    ttsp_pkg::t_in_word r_req, n_req;
    logic [SW-1:0] r_cnt,       n_cnt;
    logic [SW-1:0] r_pos,       n_pos;
    logic          r_hit,       n_hit;
    logic [SW-1:0] r_hit_idx,   n_hit_idx;
    logic          r_empty,     n_empty;
    logic [SW-1:0] r_empty_idx, n_empty_idx;
    logic          r_ev_mode,   n_ev_mode;
    logic          r_ev_found,  n_ev_found;
    logic [SW-1:0] r_ev_idx,    n_ev_idx;

    // output register
    logic                r_out_valid, n_out_valid;
    ttsp_pkg::t_out_word r_out,       n_out;

    logic [SW-1:0] rel_idx;
    logic          idx_ok;

    assign rel_idx = r_req.slot_index[SW-1:0];
    assign idx_ok  = (r_req.slot_index < ttsp_pkg::IDX_W'(N));

    assign o_stat.do_scan    = (r_req.cmd == ttsp_pkg::CMD_LOAD) && (r_req.map_id != '0);
    assign o_stat.scan_last  = (r_cnt == SW'(N - 1));
    assign o_stat.need_evict = !r_hit && (r_filled >= CW'(N));
    assign o_stat.ev_free    = !r_busy[r_pos];
    assign o_stat.ev_last    = (r_cnt == SW'(N - 1));
    assign o_stat.out_busy   = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        logic [SW-1:0] p;
        logic [CW-1:0] f1;
        logic [SW-1:0] ei;

        p  = r_ptr;
        f1 = r_filled;
        ei = r_ev_idx;

        n_busy      = r_busy;
        n_map       = r_map;
        n_filled    = r_filled;
        n_ptr       = r_ptr;
        n_last      = r_last;
        n_req       = r_req;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_empty     = r_empty;
        n_empty_idx = r_empty_idx;
        n_ev_mode   = r_ev_mode;
        n_ev_found  = r_ev_found;
        n_ev_idx    = r_ev_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.take) begin
            n_req      = i_in_word;
            n_cnt      = '0;
            n_hit      = 1'b0;
            n_empty    = 1'b0;
            n_ev_mode  = 1'b0;
            n_ev_found = 1'b0;
        end

        // one slot per cycle: first holder of the map, first empty slot
        if (i_cmd.scan_step) begin
            if (!r_hit && (r_map[r_cnt] == r_req.map_id)) begin
                n_hit     = 1'b1;
                n_hit_idx = r_cnt;
            end
            if (!r_empty && !r_busy[r_cnt] && (r_map[r_cnt] == '0)) begin
                n_empty     = 1'b1;
                n_empty_idx = r_cnt;
            end
            n_cnt = r_cnt + SW'(1);
        end

        // step past the slot holding the last map placed by eviction
        if (i_cmd.start_evict) begin
            if (r_map[r_ptr] == r_last) begin
                p = ttsp_pkg::next_slot(r_ptr);
            end
            n_ptr     = p;
            n_pos     = p;
            n_cnt     = '0;
            n_ev_mode = 1'b1;
        end

        if (i_cmd.evict_step) begin
            if (!r_busy[r_pos]) begin
                n_ev_found = 1'b1;
                n_ev_idx   = r_pos;
            end else begin
                n_pos = ttsp_pkg::next_slot(r_pos);
                n_cnt = r_cnt + SW'(1);
            end
        end

        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            unique case (r_req.cmd)
                ttsp_pkg::CMD_LOAD: begin
                    if (r_req.map_id == '0) begin
                        n_out.fault = 1'b1;
                    end else if (r_hit) begin
                        n_busy[r_hit_idx]  = 1'b1;
                        n_out.granted_slot = ttsp_pkg::GRANT_W'(r_hit_idx);
                        n_out.was_hit      = 1'b1;
                    end else if (!r_ev_mode) begin
                        if (r_empty) begin
                            n_map[r_empty_idx]  = r_req.map_id;
                            n_busy[r_empty_idx] = 1'b1;
                            if (r_filled < CW'(N)) begin
                                n_filled = r_filled + CW'(1);
                            end
                            n_out.granted_slot = ttsp_pkg::GRANT_W'(r_empty_idx);
                            n_out.needs_fill   = 1'b1;
                        end else begin
                            n_out.fault = 1'b1;
                        end
                    end else if (r_ev_found) begin
                        if (r_map[ei] != '0) begin
                            n_out.did_evict   = 1'b1;
                            n_out.evicted_map = ttsp_pkg::EVMAP_W'(r_map[ei]);
                            if (r_filled != '0) begin
                                f1 = r_filled - CW'(1);
                            end
                        end
                        n_filled           = (f1 < CW'(N)) ? f1 + CW'(1) : f1;
                        n_map[ei]          = r_req.map_id;
                        n_busy[ei]         = 1'b1;
                        n_last             = r_req.map_id;
                        n_ptr              = ttsp_pkg::next_slot(r_ptr);
                        n_out.granted_slot = ttsp_pkg::GRANT_W'(ei);
                        n_out.needs_fill   = 1'b1;
                    end else begin
                        n_out.fault = 1'b1;
                    end
                end
                ttsp_pkg::CMD_RELEASE: begin
                    if (!idx_ok) begin
                        n_out.fault = 1'b1;
                    end else if (r_map[rel_idx] != '0) begin
                        n_out.did_evict   = 1'b1;
                        n_out.evicted_map = ttsp_pkg::EVMAP_W'(r_map[rel_idx]);
                        n_map[rel_idx]    = '0;
                        n_busy[rel_idx]   = 1'b0;
                        if (r_filled != '0) begin
                            n_filled = r_filled - CW'(1);
                        end
                    end
                end
                ttsp_pkg::CMD_LIGHT: begin
                    if (!idx_ok) begin
                        n_out.fault = 1'b1;
                    end else begin
                        n_busy[rel_idx] = 1'b0;
                    end
                end
                default: begin
                    n_out.fault = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_map       <= '{default: '0};
            r_filled    <= '0;
            r_ptr       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_map       <= n_map;
            r_filled    <= n_filled;
            r_ptr       <= n_ptr;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_cnt       <= n_cnt;
        r_pos       <= n_pos;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_empty     <= n_empty;
        r_empty_idx <= n_empty_idx;
        r_ev_mode   <= n_ev_mode;
        r_ev_found  <= n_ev_found;
        r_ev_idx    <= n_ev_idx;
        r_out       <= n_out;
    end

    `TTSP_ASSERT_IMP(a_filled_in_range, i_clk, i_rst_n, 1'b1, r_filled <= CW'(N))
    `TTSP_ASSERT_IMP(a_no_commit_over_full_out, i_clk, i_rst_n, i_cmd.commit, !(r_out_valid && i_out_stall))

endmodule

`default_nettype wire

// ===== hw/rtl/ttsp_ctrl.sv =====
`default_nettype none

`include "translation_table_slot_pool_unit_macros.svh"

module ttsp_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  ttsp_pkg::t_ctrl_stat i_stat,
    output ttsp_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_EVICT  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state, n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_stat.do_scan) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.scan_last) begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (i_stat.need_evict) begin
                    o_cmd.start_evict = 1'b1;
                    n_state           = ST_EVICT;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_EVICT: begin
                o_cmd.evict_step = 1'b1;
                if (i_stat.ev_free || i_stat.ev_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `TTSP_ASSERT_NXT(a_commit_returns_idle, i_clk, i_rst_n, o_cmd.commit, r_state == ST_IDLE)
    `TTSP_ASSERT_IMP(a_evict_entry_needed, i_clk, i_rst_n, (r_state == ST_EVICT) && ($past(r_state) != ST_EVICT), $past(i_stat.need_evict))
    `TTSP_ASSERT_NXT(a_scan_end_decides, i_clk, i_rst_n, (r_state == ST_SCAN) && i_stat.do_scan && i_stat.scan_last, r_state == ST_DECIDE)

endmodule

`default_nettype wire

// ===== hw/rtl/translation_table_slot_pool_unit.sv =====
// Slot pool for address-map tables: tracks which map id each of the table
// slots holds and whether the slot is in use, and answers one word per request.
// Input channel (i_in_valid / o_in_stall / i_in_word): cmd selects load,
//   full release or light release; map_id names the map to load and
//   slot_index the slot to release. A word is taken only while idle.
// Output channel (o_out_valid / i_out_stall / o_out_word): exactly one word per
//   request: granted slot, hit, fill needed, eviction with the dropped map id,
//   and fault.
// Sequence, accept to the edge that raises o_out_valid: a release, a bad
//   command or a faulting load of map zero leaves the scan state unscanned
//   and commits; a load that hits or takes an empty slot runs the lookup
//   scan over every slot, then a decide step, then the commit; a load that
//   evicts adds the round-robin victim scan, visiting one slot per cycle,
//   before the commit. The block is free to take the next word on the
//   cycle after the result is registered.
// Receiver stall: the result sits in the output register until taken; a new
//   request is still accepted and worked on, and only its final commit waits
//   while the previous word is stalled.
// Reset (synchronous, active low): all slots empty and not busy, fill count,
//   round-robin pointer and last placed map cleared, output register empty.
`default_nettype none

module translation_table_slot_pool_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  ttsp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output ttsp_pkg::t_out_word o_out_word
);

    ttsp_pkg::t_ctrl_cmd  ctrl_cmd;
    ttsp_pkg::t_ctrl_stat ctrl_stat;

    // sequencer: idle / lookup scan / decide / victim scan / commit
    ttsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (ctrl_stat),
        .o_cmd      (ctrl_cmd)
    );

    // slot table, counters, request context and output register
    ttsp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (ctrl_cmd),
        .o_stat      (ctrl_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Command code with no meaning to the pool; the block must fault on it.
    localparam logic [ttsp_pkg::CMD_W-1:0] CMD_BAD = 2'd3;

    // No-accept cycles before the run is declared hung.
    localparam int QUIET_LIMIT = 1000;

    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 175;

    // Idle pattern of a phase: who holds off, and how often.
    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    // One pending request: the word, the idle pattern it runs under, and
    // whether the sender must wait for every outstanding result first.
    typedef struct {
        ttsp_pkg::t_in_word w;
        t_pace              pace;
        bit                 drain;
    } t_request;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    ttsp_pkg::t_in_word  in_word = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    ttsp_pkg::t_out_word out_word;

    t_request            request_q[$];
    ttsp_pkg::t_out_word slot_answer_q[$];
    t_pace               cur_pace = PACE_FULL;
    int                  sent_count = 0;
    int                  taken_count = 0;
    int                  quiet_cycles = 0;
    int                  fail_count = 0;

    // Shadow of the pool state.
    logic                             sh_busy [ttsp_pkg::SLOT_COUNT];
    logic [ttsp_pkg::MAP_ID_BITS-1:0] sh_map  [ttsp_pkg::SLOT_COUNT];
    int                               sh_filled = 0;
    int                               sh_rr = 0;
    logic [ttsp_pkg::MAP_ID_BITS-1:0] sh_last = '0;

    translation_table_slot_pool_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Fill a slot with a map and mark it in use.
    function automatic void occupy_slot(input int s,
                                        input logic [ttsp_pkg::MAP_ID_BITS-1:0] id);
        sh_map[s] = id;
        sh_busy[s] = 1'b1;
        if (sh_filled < ttsp_pkg::SLOT_COUNT) begin
            sh_filled++;
        end
    endfunction

    // Expected answer for one request word; advances the shadow state.
    function automatic ttsp_pkg::t_out_word pool_predict(input ttsp_pkg::t_in_word w);
        ttsp_pkg::t_out_word              r;
        logic [ttsp_pkg::MAP_ID_BITS-1:0] id;
        bit                               found;
        int                               p;
        int                               s;
        r = '0;
        found = 1'b0;
        id = w.map_id;
        case (w.cmd)
            ttsp_pkg::CMD_LOAD: begin
                if (id == '0) begin
                    r.fault = 1'b1;
                end else begin
                    // hit: map already resident
                    for (s = 0; s < ttsp_pkg::SLOT_COUNT && !found; s++) begin
                        if (sh_map[s] == id) begin
                            sh_busy[s] = 1'b1;
                            r.granted_slot = ttsp_pkg::GRANT_W'(s);
                            r.was_hit = 1'b1;
                            found = 1'b1;
                        end
                    end
                    if (!found && sh_filled < ttsp_pkg::SLOT_COUNT) begin
                        // first empty slot
                        for (s = 0; s < ttsp_pkg::SLOT_COUNT && !found; s++) begin
                            if (!sh_busy[s] && sh_map[s] == '0) begin
                                occupy_slot(s, id);
                                r.granted_slot = ttsp_pkg::GRANT_W'(s);
                                r.needs_fill = 1'b1;
                                found = 1'b1;
                            end
                        end
                        if (!found) begin
                            r.fault = 1'b1;
                        end
                    end else if (!found) begin
                        // round-robin victim; step past the last evict-placed map
                        p = sh_rr;
                        if (sh_map[p] == sh_last) begin
                            p = (p + 1) % ttsp_pkg::SLOT_COUNT;
                        end
                        sh_rr = p;
                        for (int j = 0; j < ttsp_pkg::SLOT_COUNT && !found; j++) begin
                            s = (p + j) % ttsp_pkg::SLOT_COUNT;
                            if (!sh_busy[s]) begin
                                if (sh_map[s] != '0) begin
                                    r.did_evict = 1'b1;
                                    r.evicted_map = ttsp_pkg::EVMAP_W'(sh_map[s]);
                                    sh_map[s] = '0;
                                    if (sh_filled > 0) begin
                                        sh_filled--;
                                    end
                                end
                                occupy_slot(s, id);
                                r.granted_slot = ttsp_pkg::GRANT_W'(s);
                                r.needs_fill = 1'b1;
                                sh_last = id;
                                sh_rr = (p + 1) % ttsp_pkg::SLOT_COUNT;
                                found = 1'b1;
                            end
                        end
                        if (!found) begin
                            r.fault = 1'b1;
                        end
                    end
                end
            end
            ttsp_pkg::CMD_RELEASE, ttsp_pkg::CMD_LIGHT: begin
                if (w.slot_index >= ttsp_pkg::SLOT_COUNT) begin
                    r.fault = 1'b1;
                end else if (w.cmd == ttsp_pkg::CMD_LIGHT) begin
                    sh_busy[w.slot_index] = 1'b0;
                end else if (sh_map[w.slot_index] != '0) begin
                    r.did_evict = 1'b1;
                    r.evicted_map = ttsp_pkg::EVMAP_W'(sh_map[w.slot_index]);
                    sh_map[w.slot_index] = '0;
                    sh_busy[w.slot_index] = 1'b0;
                    if (sh_filled > 0) begin
                        sh_filled--;
                    end
                end
            end
            default: begin
                r.fault = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int send_idle_pct(input t_pace pc);
        case (pc)
            PACE_SEND_IDLE: return 78;
            PACE_BOTH:      return 30;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input t_pace pc);
        case (pc)
            PACE_RECV_STALL: return 78;
            PACE_BOTH:       return 30;
            default:         return 0;
        endcase
    endfunction

    function automatic ttsp_pkg::t_in_word make_word(
        input logic [ttsp_pkg::CMD_W-1:0]       cmd,
        input logic [ttsp_pkg::MAP_ID_BITS-1:0] id,
        input logic [ttsp_pkg::IDX_W-1:0]       idx);
        ttsp_pkg::t_in_word w;
        w.cmd = cmd;
        w.map_id = id;
        w.slot_index = idx;
        return w;
    endfunction

    // Mostly loads from a pool of six maps (more than the slots, so evictions
    // happen) with releases to free slots; some wide ids, zero ids, bad
    // indexes and bad commands mixed in.
    function automatic ttsp_pkg::t_in_word random_request();
        ttsp_pkg::t_in_word w;
        int                 r;
        int                 k;
        w.map_id = ttsp_pkg::MAP_ID_BITS'($urandom);
        w.slot_index = ttsp_pkg::IDX_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 55) begin
            w.cmd = ttsp_pkg::CMD_LOAD;
            k = $urandom_range(0, 99);
            if (k < 85) begin
                w.map_id = ttsp_pkg::MAP_ID_BITS'($urandom_range(1, 6));
            end else if (k < 89) begin
                w.map_id = '0;
            end else if (k < 93) begin
                w.map_id = '1;
            end
        end else begin
            w.cmd = (r < 75) ? ttsp_pkg::CMD_LIGHT :
                    (r < 94) ? ttsp_pkg::CMD_RELEASE : CMD_BAD;
            if (roll(90)) begin
                w.slot_index = ttsp_pkg::IDX_W'($urandom_range(0, ttsp_pkg::SLOT_COUNT - 1));
            end
        end
        return w;
    endfunction

    task automatic queue_request(input ttsp_pkg::t_in_word w, input t_pace pc,
                                 input bit drain);
        t_request rq;
        rq.w = w;
        rq.pace = pc;
        rq.drain = drain;
        request_q.push_back(rq);
    endtask

    // Stimulus, then wait for the pool to go quiet and report.
    initial begin
        t_pace plan [RAND_PHASES];
        plan = '{PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH,
                 PACE_FULL, PACE_BOTH};
        for (int s = 0; s < ttsp_pkg::SLOT_COUNT; s++) begin
            sh_busy[s] = 1'b0;
            sh_map[s] = '0;
        end

        // Directed: zero id, fill all slots, hit, all-busy fault, evictions,
        // full releases of filled and empty slots, out-of-range indexes, bad
        // command, alternating id bits.
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0000, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0001, 3'd7), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0002, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0003, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'hFFFF, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0001, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0005, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LIGHT, 16'h0000, 3'd2), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0005, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LIGHT, 16'h0000, 3'd1), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LIGHT, 16'h0000, 3'd3), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0006, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0007, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_RELEASE, 16'hFFFF, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_RELEASE, 16'h0000, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h0008, 3'd0), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_RELEASE, 16'h0000,
                                ttsp_pkg::IDX_W'(ttsp_pkg::SLOT_COUNT)),
                      PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LIGHT, 16'h0000, 3'd7), PACE_FULL, 1'b0);
        queue_request(make_word(CMD_BAD, 16'hFFFF, 3'd7), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_RELEASE, 16'h0000, 3'd3), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LIGHT, 16'h0000, 3'd3), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'hAAAA, 3'd5), PACE_FULL, 1'b0);
        queue_request(make_word(ttsp_pkg::CMD_LOAD, 16'h5555, 3'd2), PACE_FULL, 1'b0);

        // Random phases; each opens after every earlier result is back.
        foreach (plan[ph]) begin
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                queue_request(random_request(), plan[ph], n == 0);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample on the falling edge, clear of the driver and monitor.
        while (request_q.size() != 0 || in_valid || sent_count != taken_count) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Driver: presents the head of request_q; a stalled word holds still.
    // A drain-marked word waits until every accepted word has its answer.
    always @(posedge i_clk) begin : drive_requests
        bit took;
        int pending;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            took = in_valid && !in_stall;
            if (took) begin
                slot_answer_q.push_back(pool_predict(in_word));
                sent_count <= sent_count + 1;
            end
            if (!in_valid || took) begin
                pending = sent_count + int'(took) - taken_count;
                if (request_q.size() != 0 && !(request_q[0].drain && pending != 0) &&
                    !roll(send_idle_pct(request_q[0].pace))) begin
                    in_word <= request_q[0].w;
                    cur_pace <= request_q[0].pace;
                    in_valid <= 1'b1;
                    void'(request_q.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, independent of o_out_valid.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= roll(recv_stall_pct(cur_pace));
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Monitor: every taken result word against the oldest expectation.
    always @(posedge i_clk) begin : check_answers
        ttsp_pkg::t_out_word want;
        if (i_rst_n && out_valid === 1'b1 && !out_stall) begin
            taken_count <= taken_count + 1;
            if (slot_answer_q.size() == 0) begin
                $error("result word 0x%0h with no request outstanding", out_word);
                fail_count++;
            end else begin
                want = slot_answer_q.pop_front();
                check_field("granted_slot", want.granted_slot, out_word.granted_slot);
                check_field("was_hit", want.was_hit, out_word.was_hit);
                check_field("needs_fill", want.needs_fill, out_word.needs_fill);
                check_field("did_evict", want.did_evict, out_word.did_evict);
                check_field("evicted_map", want.evicted_map, out_word.evicted_map);
                check_field("fault", want.fault, out_word.fault);
            end
        end
    end

    // Watchdog: any accept on either channel resets the quiet count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ttsp_pkg.sv
hw/rtl/ttsp_dp.sv
hw/rtl/ttsp_ctrl.sv
hw/rtl/translation_table_slot_pool_unit.sv
tb/tb_top.sv
